// ===== hdl/mpq_pkg.sv =====
// shared types, constants and the priority encoder of the multilevel ready queue
package mpq_pkg;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_POP    = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_FETCH  = 9'b000000100,
		S_LINK   = 9'b000001000,
		S_PUSH   = 9'b000010000,
		S_UNLINK = 9'b000100000,
		S_FIND1  = 9'b001000000,
		S_FIND2  = 9'b010000000,
		S_FIND3  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic fetch;
		logic link;
		logic push;
		logic unlink;
		logic finish;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  clear_last;
	} stat_t;

	// level search tree: three registered levels of eight-way encoders
	localparam int FAN    = 8;
	localparam int FAN_W  = 3;
	localparam int TREE_W = 512;
	localparam int N1     = TREE_W / FAN;
	localparam int N1_W   = 6;
	localparam int N2     = N1 / FAN;
	localparam int TOP_W  = 9;

	typedef struct packed {
		logic             any;
		logic [FAN_W-1:0] idx;
	} enc_t;

	function automatic enc_t enc8(input logic [FAN-1:0] v);
		enc_t r;
		r.any = 1'b0;
		r.idx = '0;
		for (int i = 0; i < FAN; i++) begin
			if (v[i]) begin
				r.any = 1'b1;
				r.idx = FAN_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/mpq_ctrl.sv =====
// sequencing state machine of the multilevel ready queue
module mpq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mpq_pkg::stat_t  stat,
	output mpq_pkg::cmd_t   cmd,
	output logic            busy
);

	mpq_pkg::state_t state_q;
	mpq_pkg::state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mpq_pkg::S_CLEAR: begin
				if (stat.clear_last) state_nxt = mpq_pkg::S_IDLE;
			end
			mpq_pkg::S_IDLE: begin
				if (start) state_nxt = mpq_pkg::S_FETCH;
			end
			mpq_pkg::S_FETCH: begin
				unique case (stat.mode) inside
					mpq_pkg::MODE_PUSH:                     state_nxt = mpq_pkg::S_PUSH;
					mpq_pkg::MODE_REMOVE, mpq_pkg::MODE_POP: state_nxt = mpq_pkg::S_LINK;
					default:                                state_nxt = mpq_pkg::S_FIND3;
				endcase
			end
			mpq_pkg::S_LINK:   state_nxt = mpq_pkg::S_UNLINK;
			mpq_pkg::S_PUSH:   state_nxt = mpq_pkg::S_FIND1;
			mpq_pkg::S_UNLINK: state_nxt = mpq_pkg::S_FIND1;
			mpq_pkg::S_FIND1:  state_nxt = mpq_pkg::S_FIND2;
			mpq_pkg::S_FIND2:  state_nxt = mpq_pkg::S_FIND3;
			mpq_pkg::S_FIND3:  state_nxt = mpq_pkg::S_IDLE;
			default:           state_nxt = mpq_pkg::S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpq_pkg::S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy       = (state_q != mpq_pkg::S_IDLE);
	assign cmd.clear  = (state_q == mpq_pkg::S_CLEAR);
	assign cmd.accept = (state_q == mpq_pkg::S_IDLE) && start;
	assign cmd.fetch  = (state_q == mpq_pkg::S_FETCH);
	assign cmd.link   = (state_q == mpq_pkg::S_LINK);
	assign cmd.push   = (state_q == mpq_pkg::S_PUSH);
	assign cmd.unlink = (state_q == mpq_pkg::S_UNLINK);
	assign cmd.finish = (state_q == mpq_pkg::S_FIND3);

endmodule

// ===== hdl/mpq_dp.sv =====
// pointer stores, level bitmap, level search tree and result registers
module mpq_dp #(
	parameter int NUM_LEVELS  = 64,
	parameter int MAX_ENTRIES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mpq_pkg::cmd_t  cmd,
	output mpq_pkg::stat_t stat,
	input  logic [1:0]     mode,
	input  logic [5:0]     entry_id,
	input  logic [5:0]     priority_req,
	output logic           done,
	output logic           pop_valid,
	output logic [5:0]     popped_entry,
	output logic           all_empty,
	output logic [5:0]     top_priority,
	output logic           status
);

	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	// input word
	mpq_pkg::mode_t mode_q;
	logic [5:0]     eid_q;
	logic [5:0]     pri_q;

	// stores
	logic [LW:0]   info_mem [MAX_ENTRIES];
	logic [EW-1:0] head_mem [NUM_LEVELS];
	logic [EW-1:0] tail_mem [NUM_LEVELS];
	logic [EW-1:0] next_mem [MAX_ENTRIES];
	logic [EW-1:0] prev_mem [MAX_ENTRIES];

	logic [LW:0]   info_rd_q;
	logic [EW-1:0] head_rd_q;
	logic [EW-1:0] tail_rd_q;
	logic [EW-1:0] next_rd_q;
	logic [EW-1:0] prev_rd_q;

	logic [NUM_LEVELS-1:0] level_map_q;
	logic [EW-1:0]         clr_q;

	logic [EW-1:0] e_q;
	logic [LW-1:0] lv_q;
	logic          skip_q;
	logic          pop_valid_q;
	logic [5:0]    popped_q;
	logic          status_q;

	logic [LW-1:0] top_idx_q;
	logic          top_any_q;

	// search tree
	logic [mpq_pkg::N1-1:0]    any_s1;
	logic [mpq_pkg::FAN_W-1:0] idx_s1 [mpq_pkg::N1];
	logic [mpq_pkg::N2-1:0]    any_s2;
	logic [mpq_pkg::N1_W-1:0]  idx_s2 [mpq_pkg::N2];

	logic [mpq_pkg::TREE_W-1:0] map_pad;
	mpq_pkg::enc_t              r1 [mpq_pkg::N1];
	mpq_pkg::enc_t              r2 [mpq_pkg::N2];
	mpq_pkg::enc_t              r3;
	logic [mpq_pkg::TOP_W-1:0]  top_full;
	logic [LW-1:0]              top_nxt;

	// combinational controls
	logic [EW-1:0] e_in;
	logic [LW-1:0] l_in;
	logic          eid_ok;
	logic          pri_ok;
	logic          map_hit;
	logic          push_ok;
	logic          is_head;
	logic          is_tail;
	logic [EW-1:0] e_sel;
	logic [LW-1:0] lv_sel;
	logic          rm_skip;
	logic [LW-1:0] lvl_raddr;

	logic          info_we;
	logic [EW-1:0] info_waddr;
	logic [LW:0]   info_wdata;
	logic          head_we;
	logic [LW-1:0] head_waddr;
	logic [EW-1:0] head_wdata;
	logic          tail_we;
	logic [LW-1:0] tail_waddr;
	logic [EW-1:0] tail_wdata;
	logic          next_we;
	logic [EW-1:0] next_waddr;
	logic [EW-1:0] next_wdata;
	logic          prev_we;
	logic [EW-1:0] prev_waddr;
	logic [EW-1:0] prev_wdata;

	assign e_in    = EW'(eid_q);
	assign l_in    = LW'(pri_q);
	assign eid_ok  = 32'(eid_q) < 32'(MAX_ENTRIES);
	assign pri_ok  = 32'(pri_q) < 32'(NUM_LEVELS);
	assign map_hit = level_map_q[l_in];
	assign push_ok = eid_ok && pri_ok && !info_rd_q[LW];
	assign is_head = (head_rd_q == e_q);
	assign is_tail = (tail_rd_q == e_q);
	assign e_sel   = (mode_q == mpq_pkg::MODE_REMOVE) ? e_in : head_rd_q;
	assign lv_sel  = (mode_q == mpq_pkg::MODE_REMOVE) ? info_rd_q[LW-1:0] : top_idx_q;
	assign rm_skip = !(eid_ok && info_rd_q[LW]);

	always_comb begin
		if (cmd.link) begin
			lvl_raddr = lv_sel;
		end else if (mode_q == mpq_pkg::MODE_POP) begin
			lvl_raddr = top_idx_q;
		end else begin
			lvl_raddr = l_in;
		end
	end

	always_comb begin
		info_we    = 1'b0;
		info_waddr = e_in;
		info_wdata = '0;
		head_we    = 1'b0;
		head_waddr = l_in;
		head_wdata = e_in;
		tail_we    = 1'b0;
		tail_waddr = l_in;
		tail_wdata = e_in;
		next_we    = 1'b0;
		next_waddr = tail_rd_q;
		next_wdata = e_in;
		prev_we    = 1'b0;
		prev_waddr = e_in;
		prev_wdata = tail_rd_q;
		if (cmd.clear) begin
			info_we    = 1'b1;
			info_waddr = clr_q;
		end
		if (cmd.push && push_ok) begin
			info_we    = 1'b1;
			info_wdata = {1'b1, l_in};
			tail_we    = 1'b1;
			if (map_hit) begin
				prev_we = 1'b1;
				next_we = 1'b1;
			end else begin
				head_we = 1'b1;
			end
		end
		if (cmd.unlink && !skip_q) begin
			info_we    = 1'b1;
			info_waddr = e_q;
			info_wdata = {1'b0, lv_q};
			head_waddr = lv_q;
			head_wdata = next_rd_q;
			tail_waddr = lv_q;
			tail_wdata = prev_rd_q;
			next_waddr = prev_rd_q;
			next_wdata = next_rd_q;
			prev_waddr = next_rd_q;
			prev_wdata = prev_rd_q;
			if (is_head && !is_tail) begin
				head_we = 1'b1;
			end else if (is_tail && !is_head) begin
				tail_we = 1'b1;
			end else if (!is_head && !is_tail) begin
				next_we = 1'b1;
				prev_we = 1'b1;
			end
		end
	end

	// stores, one write and one registered read each
	always_ff @(posedge clk) begin
		if (info_we) info_mem[info_waddr] <= info_wdata;
		info_rd_q <= info_mem[e_in];
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_waddr] <= head_wdata;
		head_rd_q <= head_mem[lvl_raddr];
	end

	always_ff @(posedge clk) begin
		if (tail_we) tail_mem[tail_waddr] <= tail_wdata;
		tail_rd_q <= tail_mem[lvl_raddr];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_waddr] <= next_wdata;
		next_rd_q <= next_mem[e_sel];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
		prev_rd_q <= prev_mem[e_sel];
	end

	// input word and per-operation registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mpq_pkg::mode_t'(mode);
			eid_q  <= entry_id;
			pri_q  <= priority_req;
		end
		if (cmd.link) begin
			e_q  <= e_sel;
			lv_q <= lv_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_map_q <= '0;
			clr_q       <= '0;
			skip_q      <= 1'b1;
			pop_valid_q <= 1'b0;
			popped_q    <= '0;
			status_q    <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cmd.accept) begin
				pop_valid_q <= 1'b0;
				popped_q    <= '0;
				status_q    <= 1'b0;
			end
			if (cmd.link) begin
				if (mode_q == mpq_pkg::MODE_REMOVE) begin
					skip_q   <= rm_skip;
					status_q <= rm_skip;
				end else begin
					skip_q      <= !top_any_q;
					pop_valid_q <= top_any_q;
					popped_q    <= top_any_q ? 6'(head_rd_q) : 6'd0;
				end
			end
			if (cmd.push) begin
				status_q <= !push_ok;
				if (push_ok && !map_hit) level_map_q[l_in] <= 1'b1;
			end
			if (cmd.unlink && !skip_q && is_head && is_tail) level_map_q[lv_q] <= 1'b0;
		end
	end

	// highest non-empty level, three registered encoder levels
	assign map_pad = mpq_pkg::TREE_W'(level_map_q);

	always_comb begin
		for (int g = 0; g < mpq_pkg::N1; g++) begin
			r1[g] = mpq_pkg::enc8(map_pad[g*mpq_pkg::FAN +: mpq_pkg::FAN]);
		end
		for (int h = 0; h < mpq_pkg::N2; h++) begin
			r2[h] = mpq_pkg::enc8(any_s1[h*mpq_pkg::FAN +: mpq_pkg::FAN]);
		end
	end

	assign r3       = mpq_pkg::enc8(any_s2);
	assign top_full = {r3.idx, idx_s2[r3.idx]};
	assign top_nxt  = LW'(top_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_s1    <= '0;
			any_s2    <= '0;
			top_idx_q <= '0;
			top_any_q <= 1'b0;
			for (int g = 0; g < mpq_pkg::N1; g++) idx_s1[g] <= '0;
			for (int h = 0; h < mpq_pkg::N2; h++) idx_s2[h] <= '0;
		end else begin
			for (int g = 0; g < mpq_pkg::N1; g++) begin
				any_s1[g] <= r1[g].any;
				idx_s1[g] <= r1[g].idx;
			end
			for (int h = 0; h < mpq_pkg::N2; h++) begin
				any_s2[h] <= r2[h].any;
				idx_s2[h] <= {r2[h].idx, idx_s1[{mpq_pkg::FAN_W'(h), r2[h].idx}]};
			end
			top_idx_q <= top_nxt;
			top_any_q <= r3.any;
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done         <= 1'b0;
			pop_valid    <= 1'b0;
			popped_entry <= '0;
			all_empty    <= 1'b1;
			top_priority <= '0;
			status       <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.finish) begin
				pop_valid    <= pop_valid_q;
				popped_entry <= popped_q;
				all_empty    <= !r3.any;
				top_priority <= 6'(top_nxt);
				status       <= status_q;
			end
		end
	end

	assign stat.mode       = mode_q;
	assign stat.clear_last = (clr_q == EW'(MAX_ENTRIES - 1));

endmodule

// ===== hdl/multilevel_priority_ready_queue_top.sv =====
// top level of the multilevel priority ready queue
// the next word is taken in the cycle that done is high, one word at a time
// a push does one store read and one write, a remove or pop two store reads and one
// write, then the level search follows; a query the store read and only the last search step
// after reset the entry store is swept with busy high; done is a one-cycle strobe and
// the receiver cannot stall
module multilevel_priority_ready_queue_top #(
	parameter int NUM_LEVELS  = 64,
	parameter int MAX_ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [5:0] entry_id,
	input  logic [5:0] priority_req,
	output logic       done,
	output logic       pop_valid,
	output logic [5:0] popped_entry,
	output logic       all_empty,
	output logic [5:0] top_priority,
	output logic       status
);

	mpq_pkg::cmd_t  cmd;
	mpq_pkg::stat_t stat;

	mpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	mpq_dp #(
		.NUM_LEVELS  (NUM_LEVELS),
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.entry_id     (entry_id),
		.priority_req (priority_req),
		.done         (done),
		.pop_valid    (pop_valid),
		.popped_entry (popped_entry),
		.all_empty    (all_empty),
		.top_priority (top_priority),
		.status       (status)
	);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(done && all_empty) |-> (top_priority == 6'd0))
		else $error("empty queue with nonzero top priority");

endmodule

// ===== tb/tb_multilevel_priority_ready_queue_top.sv =====
// testbench for the multilevel priority ready queue: directed table, then random words
`timescale 1ns / 1ps

module tb_multilevel_priority_ready_queue_top;

	localparam int STALL_LIMIT = 2000;
	localparam int GAP_MAX     = 12;
	localparam int TAIL_CYCLES = 10;

	typedef struct packed {
		logic       pop_valid;
		logic [5:0] popped_entry;
		logic       all_empty;
		logic [5:0] top_priority;
		logic       status;
	} rq_report_t;

	typedef struct packed {
		mpq_pkg::mode_t op;
		logic [5:0]     id;
		logic [5:0]     pri;
		logic           typed;
		rq_report_t     want;
	} stim_row_t;

	localparam rq_report_t RPT_EMPTY = '{1'b0, 6'd0, 1'b1, 6'd0, 1'b0};
	localparam rq_report_t RPT_NONE  = '0;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	mpq_pkg::mode_t mode = mpq_pkg::MODE_QUERY;
	logic [5:0]     entry_id = '0;
	logic [5:0]     priority_req = '0;
	logic           busy;
	logic           done;
	logic           pop_valid;
	logic [5:0]     popped_entry;
	logic           all_empty;
	logic [5:0]     top_priority;
	logic           status;

	// predicted queue contents
	logic [63:0] lvl_nonempty;
	logic [5:0]  lvl_head [64];
	logic [5:0]  lvl_tail [64];
	logic [5:0]  nxt_slot [64];
	logic [5:0]  prv_slot [64];
	logic        slot_queued [64];
	logic [5:0]  slot_level [64];

	rq_report_t reports_due [$];
	stim_row_t  dir_tab [$];
	int         mism = 0;
	int         stall_cnt = 0;

	multilevel_priority_ready_queue_top #(
		.NUM_LEVELS(64),
		.MAX_ENTRIES(64)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.entry_id(entry_id),
		.priority_req(priority_req),
		.done(done),
		.pop_valid(pop_valid),
		.popped_entry(popped_entry),
		.all_empty(all_empty),
		.top_priority(top_priority),
		.status(status)
	);

	always #10 clk = ~clk;

	function automatic bit find_top_level(output logic [5:0] lv);
		lv = '0;
		for (int l = 63; l >= 0; l--) begin
			if (lvl_nonempty[l]) begin
				lv = 6'(l);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void unlink_slot(input logic [5:0] e, input logic [5:0] lv);
		logic       at_head;
		logic       at_tail;
		logic [5:0] p;
		logic [5:0] n;
		at_head = (lvl_head[lv] == e);
		at_tail = (lvl_tail[lv] == e);
		p = prv_slot[e];
		n = nxt_slot[e];
		if (at_head && at_tail) begin
			lvl_nonempty[lv] = 1'b0;
		end else if (at_head) begin
			lvl_head[lv] = n;
		end else if (at_tail) begin
			lvl_tail[lv] = p;
			nxt_slot[p] = p;
		end else begin
			nxt_slot[p] = n;
			prv_slot[n] = p;
		end
		slot_queued[e] = 1'b0;
	endfunction

	function automatic rq_report_t sched_step(input mpq_pkg::mode_t op,
			input logic [5:0] id, input logic [5:0] pri);
		rq_report_t r;
		logic [5:0] top;
		logic [5:0] e;
		bit         any;
		r = '0;
		case (op)
			mpq_pkg::MODE_PUSH: begin
				if (slot_queued[id]) begin
					r.status = 1'b1;
				end else begin
					if (lvl_nonempty[pri]) begin
						nxt_slot[lvl_tail[pri]] = id;
						prv_slot[id] = lvl_tail[pri];
					end else begin
						lvl_head[pri] = id;
						lvl_nonempty[pri] = 1'b1;
						prv_slot[id] = id;
					end
					nxt_slot[id] = id;
					lvl_tail[pri] = id;
					slot_queued[id] = 1'b1;
					slot_level[id] = pri;
				end
			end
			mpq_pkg::MODE_REMOVE: begin
				if (!slot_queued[id])
					r.status = 1'b1;
				else
					unlink_slot(id, slot_level[id]);
			end
			mpq_pkg::MODE_POP: begin
				if (find_top_level(top)) begin
					e = lvl_head[top];
					unlink_slot(e, top);
					r.pop_valid = 1'b1;
					r.popped_entry = e;
				end
			end
			default: begin
			end
		endcase
		any = find_top_level(top);
		r.all_empty = !any;
		r.top_priority = top;
		return r;
	endfunction

	function automatic stim_row_t row(input mpq_pkg::mode_t op, input int id, input int pri,
			input logic typed = 1'b0, input rq_report_t want = RPT_NONE);
		row = '{op, 6'(id), 6'(pri), typed, want};
	endfunction

	function automatic logic [5:0] pick_slot(input bit want_queued);
		int         base;
		logic [5:0] s;
		base = $urandom_range(0, 63);
		for (int k = 0; k < 64; k++) begin
			s = 6'(base + k);
			if (slot_queued[s] == want_queued)
				return s;
		end
		return 6'(base);
	endfunction

	task automatic send_word(input stim_row_t r, input int idle_pct);
		int         gap;
		rq_report_t want;
		gap = 0;
		while (gap < GAP_MAX && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			// idle cycles counted from the first cycle the block is ready
			do @(posedge clk); while (busy);
			repeat (gap - 1) @(posedge clk);
		end
		start <= 1'b1;
		mode <= r.op;
		entry_id <= r.id;
		priority_req <= r.pri;
		do @(posedge clk); while (busy);
		want = sched_step(r.op, r.id, r.pri);
		reports_due.push_back(r.typed ? r.want : want);
	endtask

	task automatic drain_reports();
		start <= 1'b0;
		do @(posedge clk); while (reports_due.size() != 0);
	endtask

	task automatic run_phase(input int n, input int idle_pct);
		int         nq;
		int         sel;
		int         push_thr;
		stim_row_t  r;
		for (int i = 0; i < n; i++) begin
			nq = 0;
			foreach (slot_queued[k])
				nq += slot_queued[k];
			push_thr = (nq < 8) ? 55 : ((nq > 40) ? 20 : 38);
			sel = $urandom_range(0, 99);
			r = row(mpq_pkg::MODE_QUERY, $urandom_range(0, 63), $urandom_range(0, 63));
			if (sel < push_thr) begin
				r.op = mpq_pkg::MODE_PUSH;
				// mostly free slots, some double pushes
				r.id = ($urandom_range(0, 99) < 88) ? pick_slot(1'b0) :
					6'($urandom_range(0, 63));
				sel = $urandom_range(0, 99);
				if (sel < 40)
					r.pri = 6'($urandom_range(0, 2));
				else if (sel < 60)
					r.pri = 6'($urandom_range(61, 63));
			end else if (sel < push_thr + 20) begin
				r.op = mpq_pkg::MODE_REMOVE;
				r.id = ($urandom_range(0, 99) < 85) ? pick_slot(1'b1) :
					6'($urandom_range(0, 63));
			end else if (sel < push_thr + 45) begin
				r.op = mpq_pkg::MODE_POP;
			end
			send_word(r, idle_pct);
		end
	endtask

	function automatic bit report_ok(input rq_report_t a, input rq_report_t b);
		return a.pop_valid === b.pop_valid && a.popped_entry === b.popped_entry &&
			a.all_empty === b.all_empty && a.top_priority === b.top_priority &&
			a.status === b.status;
	endfunction

	always @(posedge clk) begin : result_check
		rq_report_t got;
		rq_report_t want;
		if (arst_n && done) begin
			got = '{pop_valid, popped_entry, all_empty, top_priority, status};
			if (reports_due.size() == 0) begin
				mism++;
				$display({"%0t: unexpected word: expected none, ",
					"got pv=%0d pe=%0d empty=%0d top=%0d st=%0d"},
					$time, got.pop_valid, got.popped_entry, got.all_empty,
					got.top_priority, got.status);
			end else begin
				want = reports_due.pop_front();
				if (!report_ok(want, got)) begin
					mism++;
					$display({"%0t: expected pv=%0d pe=%0d empty=%0d top=%0d st=%0d, ",
						"got pv=%0d pe=%0d empty=%0d top=%0d st=%0d"},
						$time, want.pop_valid, want.popped_entry, want.all_empty,
						want.top_priority, want.status, got.pop_valid,
						got.popped_entry, got.all_empty, got.top_priority, got.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		lvl_nonempty = '0;
		for (int i = 0; i < 64; i++) begin
			lvl_head[i] = '0;
			lvl_tail[i] = '0;
			nxt_slot[i] = '0;
			prv_slot[i] = '0;
			slot_queued[i] = 1'b0;
			slot_level[i] = '0;
		end

		dir_tab.push_back(row(mpq_pkg::MODE_QUERY, 0, 0, 1'b1, RPT_EMPTY));
		dir_tab.push_back(row(mpq_pkg::MODE_POP, 0, 0, 1'b1, RPT_EMPTY));
		dir_tab.push_back(row(mpq_pkg::MODE_REMOVE, 5, 63, 1'b1,
			'{1'b0, 6'd0, 1'b1, 6'd0, 1'b1}));
		dir_tab.push_back(row(mpq_pkg::MODE_PUSH, 63, 63, 1'b1,
			'{1'b0, 6'd0, 1'b0, 6'd63, 1'b0}));
		dir_tab.push_back(row(mpq_pkg::MODE_PUSH, 63, 0, 1'b1,
			'{1'b0, 6'd0, 1'b0, 6'd63, 1'b1}));
		dir_tab.push_back(row(mpq_pkg::MODE_PUSH, 0, 0, 1'b1,
			'{1'b0, 6'd0, 1'b0, 6'd63, 1'b0}));
		dir_tab.push_back(row(mpq_pkg::MODE_PUSH, 1, 0));
		dir_tab.push_back(row(mpq_pkg::MODE_PUSH, 2, 0));
		dir_tab.push_back(row(mpq_pkg::MODE_PUSH, 3, 63));
		// middle, then tail, then lone entry of a level; priority field ignored
		dir_tab.push_back(row(mpq_pkg::MODE_REMOVE, 1, 42));
		dir_tab.push_back(row(mpq_pkg::MODE_REMOVE, 2, 0));
		dir_tab.push_back(row(mpq_pkg::MODE_REMOVE, 0, 63));
		dir_tab.push_back(row(mpq_pkg::MODE_PUSH, 10, 32));
		dir_tab.push_back(row(mpq_pkg::MODE_PUSH, 11, 32));
		dir_tab.push_back(row(mpq_pkg::MODE_PUSH, 12, 32));
		dir_tab.push_back(row(mpq_pkg::MODE_REMOVE, 10, 0));
		dir_tab.push_back(row(mpq_pkg::MODE_REMOVE, 10, 0));
		dir_tab.push_back(row(mpq_pkg::MODE_POP, 0, 0));
		dir_tab.push_back(row(mpq_pkg::MODE_POP, 0, 0));
		dir_tab.push_back(row(mpq_pkg::MODE_POP, 0, 0));
		dir_tab.push_back(row(mpq_pkg::MODE_POP, 0, 0));
		dir_tab.push_back(row(mpq_pkg::MODE_POP, 63, 63));
		dir_tab.push_back(row(mpq_pkg::MODE_QUERY, 63, 63));
		dir_tab.push_back(row(mpq_pkg::MODE_PUSH, 42, 21));
		dir_tab.push_back(row(mpq_pkg::MODE_QUERY, 21, 42));

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i], 0);
		drain_reports();

		run_phase(300, 32);
		drain_reports();
		run_phase(300, 67);
		drain_reports();
		run_phase(250, 0);
		drain_reports();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mism == 0 && reports_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== multilevel_priority_ready_queue_top.f =====
hdl/mpq_pkg.sv
hdl/mpq_ctrl.sv
hdl/mpq_dp.sv
hdl/multilevel_priority_ready_queue_top.sv
tb/tb_multilevel_priority_ready_queue_top.sv
